// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// depends on clk and arst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset only
`define BLGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BLGR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/blgr_pkg.sv =====
// types, constants and fixed-point helpers for the lapse gauge rate block
// no dependencies
package blgr_pkg;

	localparam int FRAC_BITS = 24;
	localparam int LOG_STEPS = 32;
	// log unit: normalize, squaring steps, partial products, final sum
	localparam int LN_LAT = LOG_STEPS + 3;
	localparam int STG_LN = 1 + LN_LAT;
	localparam int PIPE_DEPTH = STG_LN + 5;
	localparam int LN_SHIFT = 57 - FRAC_BITS;

	// gauge modes
	localparam logic [2:0] MODE_STATIC = 3'd0;
	localparam logic [2:0] MODE_HARMONIC = 3'd1;
	localparam logic [2:0] MODE_ANHARM = 3'd2;
	localparam logic [2:0] MODE_ONE_LOG = 3'd3;
	localparam logic [2:0] MODE_DAMPED = 3'd4;
	localparam logic [2:0] MODE_SYNC = 3'd5;
	localparam logic [2:0] MODE_GWAVE = 3'd6;

	// register indexes
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_K_OFFSET = 3'd1;
	localparam logic [2:0] REG_LOG_COEF = 3'd2;
	localparam logic [2:0] REG_DAMPING = 3'd3;
	localparam logic [2:0] REG_POWER = 3'd4;

	localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [32:0] THREE_FX = 33'sd3 <<< FRAC_BITS;
	localparam logic signed [64:0] ROUND_HALF = 65'sd1 <<< (FRAC_BITS - 1);
	localparam logic [24:0] LN2_Q25 = 25'd23258160;
	localparam logic signed [25:0] LN2_Q25_S = 26'sd23258160;
	localparam logic signed [66:0] LN_HALF = 67'sd1 <<< (LN_SHIFT - 1);
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
	localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

	typedef struct packed {
		logic clip;
		logic signed [31:0] v;
	} res_t;

	typedef struct packed {
		logic signed [31:0] r_early;
		logic c_early;
		logic signed [31:0] a2;
		logic signed [33:0] adv;
		logic signed [31:0] curv;
		logic signed [31:0] t1;
		logic c4;
		logic derr;
	} side_t;

	typedef struct packed {
		logic signed [31:0] rate;
		logic clip;
		logic derr;
	} out_t;

	// clip a wide value to the signed 32-bit range
	function automatic res_t sat32(input logic signed [65:0] x);
		res_t r;
		if (x > S32_MAX_W) begin
			r.clip = 1'b1;
			r.v = 32'sh7FFFFFFF;
		end else if (x < S32_MIN_W) begin
			r.clip = 1'b1;
			r.v = 32'sh80000000;
		end else begin
			r.clip = 1'b0;
			r.v = x[31:0];
		end
		return r;
	endfunction

	// round a raw product back to fixed point, then clip
	function automatic res_t rnd_mul(input logic signed [63:0] p);
		logic signed [64:0] q;
		q = 65'(p) + ROUND_HALF;
		return sat32(66'(q >>> FRAC_BITS));
	endfunction

endpackage

// ===== hdl/blgr_ln.sv =====
// natural log pipeline: normalize, squaring steps for log2, scale by ln 2
// depends on blgr_pkg
module blgr_ln import blgr_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic signed [31:0] lapse,
	output logic signed [31:0] ln_val,
	output logic ln_clip
);

	logic [31:0] m_s [0:LOG_STEPS];
	logic [4:0] e_s [0:LOG_STEPS];
	logic [31:0] f_s [0:LOG_STEPS];
	logic [56:0] lo_s33;
	logic signed [32:0] hi_s33;
	res_t ln_s34;

	logic [31:0] au;
	logic [4:0] lead;
	logic [31:0] m_norm;
	logic signed [6:0] ek;
	logic signed [66:0] tot;

	// leading one position and mantissa in [1,2)
	always_comb begin
		au = lapse;
		lead = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (au[i]) lead = 5'(i);
		end
		m_norm = au << (5'd31 - lead);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= m_norm;
			e_s[0] <= lead;
			f_s[0] <= '0;
		end
	end

	// one squaring step per stage, one fraction bit each
	for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_step
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = m_s[j-1] * m_s[j-1];
		assign t = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j] <= t[32] ? t[32:1] : t[31:0];
				f_s[j] <= {f_s[j-1][30:0], t[32]};
				e_s[j] <= e_s[j-1];
			end
		end
	end

	// partial products of log2 times ln 2
	assign ek = $signed({2'b00, e_s[LOG_STEPS]}) - 7'sd24;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s33 <= f_s[LOG_STEPS] * LN2_Q25;
			hi_s33 <= ek * LN2_Q25_S;
		end
	end

	// recombine, round and clip
	assign tot = (67'(hi_s33) <<< 32) + $signed({10'b0, lo_s33}) + LN_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s34 <= sat32(66'(tot >>> LN_SHIFT));
		end
	end

	assign ln_val = ln_s34.v;
	assign ln_clip = ln_s34.clip;

endmodule

// ===== hdl/bssn_lapse_gauge_rate.sv =====
// Lapse gauge rate: one grid point per cycle in, one lapse rate per cycle out while
// out_ready is high and no result waits in the skid register. All modes share one
// pipeline whose depth is set by the natural log unit used in damped-wave mode, a
// 32-stage squaring pipeline with one 32x32 multiplier per stage. in_ready drops only
// when both the output register and its skid register hold results.
// depends on blgr_pkg and blgr_ln
module bssn_lapse_gauge_rate import blgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] lapse,
	input  logic signed [31:0] curv_trace,
	input  logic signed [31:0] conf_factor,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic signed [31:0] lapse_dx,
	input  logic signed [31:0] lapse_dy,
	input  logic signed [31:0] lapse_dz,
	input  logic signed [31:0] background_curv,
	input  logic signed [31:0] curv_difference,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] lapse_rate,
	output logic saturated,
	output logic domain_error
);

	logic [2:0] mode_q;
	logic signed [31:0] koff_q, coef_q, mu_q, pw_q;

	logic en;
	logic [PIPE_DEPTH:1] vld_s;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STATIC;
			koff_q <= '0;
			coef_q <= ONE_FX;
			mu_q <= '0;
			pw_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[2:0];
				REG_K_OFFSET: koff_q <= cfg_data;
				REG_LOG_COEF: coef_q <= cfg_data;
				REG_DAMPING: mu_q <= cfg_data;
				REG_POWER: pw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], in_valid};
		end
	end

	// stage 1: input register
	logic signed [31:0] a_s1, k_s1, phi_s1, bx_s1, by_s1, bz_s1;
	logic signed [31:0] dx_s1, dy_s1, dz_s1, kb_s1, d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= lapse;
			k_s1 <= curv_trace;
			phi_s1 <= conf_factor;
			bx_s1 <= shift_x;
			by_s1 <= shift_y;
			bz_s1 <= shift_z;
			dx_s1 <= lapse_dx;
			dy_s1 <= lapse_dy;
			dz_s1 <= lapse_dz;
			kb_s1 <= background_curv;
			d_s1 <= curv_difference;
		end
	end

	// stage 2: raw products and offset sums
	logic signed [63:0] paa_s2, pak_s2, pakb_s2, px_s2, py_s2, pz_s2, ppp_s2;
	logic signed [32:0] dkk_s2, dk3_s2;
	logic signed [31:0] k_s2, d_s2;
	logic apos_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			paa_s2 <= a_s1 * a_s1;
			pak_s2 <= a_s1 * k_s1;
			pakb_s2 <= a_s1 * kb_s1;
			px_s2 <= bx_s1 * dx_s1;
			py_s2 <= by_s1 * dy_s1;
			pz_s2 <= bz_s1 * dz_s1;
			ppp_s2 <= phi_s1 * pw_q;
			dkk_s2 <= 33'(k_s1) - 33'(koff_q);
			dk3_s2 <= 33'(k_s1) + THREE_FX;
			k_s2 <= k_s1;
			d_s2 <= d_s1;
			apos_s2 <= !a_s1[31] && (a_s1 != '0);
		end
	end

	// stage 3: round products, clip sums, advection sum
	res_t r_a2, r_ak, r_nk, r_x, r_y, r_z, r_pp, r_kk, r_k3;
	logic signed [31:0] a2_s3, akm_s3, nk_s3, pp_s3, skk_s3, sk3_s3, k_s3, d_s3;
	logic signed [33:0] adv_s3;
	logic c_a2_s3, c_ak_s3, c_nk_s3, c_adv_s3, c_pp_s3, c_kk_s3, c_k3_s3, apos_s3;

	always_comb begin
		r_a2 = rnd_mul(paa_s2);
		r_ak = rnd_mul(pak_s2);
		r_nk = rnd_mul(pakb_s2);
		r_x = rnd_mul(px_s2);
		r_y = rnd_mul(py_s2);
		r_z = rnd_mul(pz_s2);
		r_pp = rnd_mul(ppp_s2);
		r_kk = sat32(66'(dkk_s2));
		r_k3 = sat32(66'(dk3_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s3 <= r_a2.v;
			akm_s3 <= r_ak.v;
			nk_s3 <= r_nk.v;
			pp_s3 <= r_pp.v;
			skk_s3 <= r_kk.v;
			sk3_s3 <= r_k3.v;
			adv_s3 <= 34'(r_x.v) + 34'(r_y.v) + 34'(r_z.v);
			c_a2_s3 <= r_a2.clip;
			c_ak_s3 <= r_ak.clip;
			c_nk_s3 <= r_nk.clip;
			c_adv_s3 <= r_x.clip | r_y.clip | r_z.clip;
			c_pp_s3 <= r_pp.clip;
			c_kk_s3 <= r_kk.clip;
			c_k3_s3 <= r_k3.clip;
			k_s3 <= k_s2;
			d_s3 <= d_s2;
			apos_s3 <= apos_s2;
		end
	end

	// stage 4: second products, divide-by-three operand, twelve times phi term
	logic signed [31:0] msel;
	logic cm_base;
	logic signed [35:0] t12;
	res_t r_t1;
	logic [31:0] u5;
	logic signed [63:0] pm_s4, pc_s4;
	logic [31:0] u_s4;
	logic neg_s4, cm_s4, cc_s4, c5_s4, c4_s4, apos_s4;
	logic signed [31:0] t1_s4, a2_s4, k_s4;
	logic signed [33:0] adv_s4;

	always_comb begin
		case (mode_q)
			MODE_HARMONIC: begin
				msel = skk_s3;
				cm_base = c_a2_s3 | c_kk_s3;
			end
			MODE_ANHARM: begin
				msel = sk3_s3;
				cm_base = c_a2_s3 | c_k3_s3;
			end
			default: begin
				msel = d_s3;
				cm_base = c_a2_s3;
			end
		endcase
		t12 = pp_s3 * 36'sd12;
		r_t1 = sat32(66'(t12));
		// rounded divide operand: one plus the magnitude of the negated product
		if (nk_s3 > 0) u5 = 32'(nk_s3) + 32'd1;
		else u5 = 32'd1 - 32'(nk_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s4 <= a2_s3 * msel;
			pc_s4 <= akm_s3 * coef_q;
			u_s4 <= u5;
			neg_s4 <= nk_s3 > 0;
			cm_s4 <= cm_base;
			cc_s4 <= c_ak_s3 | c_adv_s3;
			c5_s4 <= c_nk_s3;
			t1_s4 <= r_t1.v;
			c4_s4 <= c_pp_s3 | r_t1.clip | c_a2_s3 | c_adv_s3;
			a2_s4 <= a2_s3;
			k_s4 <= k_s3;
			adv_s4 <= adv_s3;
			apos_s4 <= apos_s3;
		end
	end

	// stage 5: round second products, reciprocal multiply
	res_t r_m, r_c;
	logic signed [31:0] rm_s5, rc_s5, t1_s5, a2_s5, k_s5;
	logic [63:0] pu_s5;
	logic cm_s5, cc_s5, neg_s5, c5_s5, c4_s5, apos_s5;
	logic signed [33:0] adv_s5;

	always_comb begin
		r_m = rnd_mul(pm_s4);
		r_c = rnd_mul(pc_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rm_s5 <= r_m.v;
			rc_s5 <= r_c.v;
			cm_s5 <= cm_s4 | r_m.clip;
			cc_s5 <= cc_s4 | r_c.clip;
			pu_s5 <= u_s4 * RECIP3;
			neg_s5 <= neg_s4;
			c5_s5 <= c5_s4;
			t1_s5 <= t1_s4;
			c4_s5 <= c4_s4;
			a2_s5 <= a2_s4;
			k_s5 <= k_s4;
			adv_s5 <= adv_s4;
			apos_s5 <= apos_s4;
		end
	end

	// stage 6: results of every mode but damped wave
	res_t r_neg, r_one;
	logic signed [34:0] e3;
	logic signed [31:0] q5;
	side_t side_nxt;
	side_t side_s [6:STG_LN];

	always_comb begin
		r_neg = sat32(66'(33'sd0 - 33'(rm_s5)));
		e3 = 35'(adv_s5) - (35'(rc_s5) <<< 1);
		r_one = sat32(66'(e3));
		q5 = $signed({1'b0, pu_s5[63:33]});
		side_nxt.a2 = a2_s5;
		side_nxt.adv = adv_s5;
		side_nxt.curv = k_s5;
		side_nxt.t1 = t1_s5;
		side_nxt.c4 = c4_s5;
		side_nxt.derr = (mode_q == MODE_DAMPED) && !apos_s5;
		case (mode_q) inside
			MODE_HARMONIC, MODE_GWAVE: begin
				side_nxt.r_early = r_neg.v;
				side_nxt.c_early = cm_s5 | r_neg.clip;
			end
			MODE_ANHARM: begin
				side_nxt.r_early = rm_s5;
				side_nxt.c_early = cm_s5;
			end
			MODE_ONE_LOG: begin
				side_nxt.r_early = r_one.v;
				side_nxt.c_early = cc_s5 | r_one.clip;
			end
			MODE_SYNC: begin
				side_nxt.r_early = neg_s5 ? -q5 : q5;
				side_nxt.c_early = c5_s5;
			end
			default: begin
				side_nxt.r_early = '0;
				side_nxt.c_early = 1'b0;
			end
		endcase
	end

	// wait for the log unit
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[6] <= side_nxt;
			for (int i = 7; i <= STG_LN; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	logic signed [31:0] ln_v;
	logic ln_c;

	blgr_ln u_ln (
		.clk(clk),
		.en(en),
		.lapse(a_s1),
		.ln_val(ln_v),
		.ln_clip(ln_c)
	);

	// stage 37: exponent term minus log
	res_t r_t2;
	logic signed [31:0] t2_s37;
	logic c_s37;
	side_t side_s37;

	assign r_t2 = sat32(66'(33'(side_s[STG_LN].t1) - 33'(ln_v)));

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s37 <= r_t2.v;
			c_s37 <= side_s[STG_LN].c4 | ln_c | r_t2.clip;
			side_s37 <= side_s[STG_LN];
		end
	end

	// stage 38: damping product
	logic signed [63:0] pmu_s38;
	logic c_s38;
	side_t side_s38;

	always_ff @(posedge clk) begin
		if (en) begin
			pmu_s38 <= mu_q * t2_s37;
			c_s38 <= c_s37;
			side_s38 <= side_s37;
		end
	end

	// stage 39: round and subtract curvature
	res_t r_mu, r_t3;
	logic signed [31:0] t3_s39;
	logic c_s39;
	side_t side_s39;

	always_comb begin
		r_mu = rnd_mul(pmu_s38);
		r_t3 = sat32(66'(33'(r_mu.v) - 33'(side_s38.curv)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t3_s39 <= r_t3.v;
			c_s39 <= c_s38 | r_mu.clip | r_t3.clip;
			side_s39 <= side_s38;
		end
	end

	// stage 40: lapse squared times bracket
	logic signed [63:0] pf_s40;
	logic c_s40;
	side_t side_s40;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s40 <= side_s39.a2 * t3_s39;
			c_s40 <= c_s39;
			side_s40 <= side_s39;
		end
	end

	// stage 41: add advection, pick the mode's result
	res_t r_f, r_4;
	out_t res_nxt, res_s41;

	always_comb begin
		r_f = rnd_mul(pf_s40);
		r_4 = sat32(66'(35'(r_f.v) + 35'(side_s40.adv)));
		res_nxt.derr = 1'b0;
		if (mode_q == MODE_DAMPED) begin
			if (side_s40.derr) begin
				res_nxt.rate = '0;
				res_nxt.clip = 1'b0;
				res_nxt.derr = 1'b1;
			end else begin
				res_nxt.rate = r_4.v;
				res_nxt.clip = c_s40 | r_f.clip | r_4.clip;
			end
		end else begin
			res_nxt.rate = side_s40.r_early;
			res_nxt.clip = side_s40.c_early;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s41 <= res_nxt;
		end
	end

	// output register with skid stage
	logic out_vld_q, skid_vld_q;
	out_t out_res_q, skid_res_q;
	logic out_take;

	assign out_take = out_vld_q && out_ready;
	assign en = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) skid_vld_q <= 1'b0;
		end else if (vld_s[PIPE_DEPTH]) begin
			if (!out_vld_q || out_take) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) out_res_q <= skid_res_q;
		end else if (vld_s[PIPE_DEPTH]) begin
			if (!out_vld_q || out_take) out_res_q <= res_s41;
			else skid_res_q <= res_s41;
		end
	end

	assign out_valid = out_vld_q;
	assign lapse_rate = out_res_q.rate;
	assign saturated = out_res_q.clip;
	assign domain_error = out_res_q.derr;

endmodule

// ===== hdl/blgr_chk.sv =====
// port-level checker for the lapse gauge rate block, bound to the top level
// depends on blgr_pkg and assert_macros.svh
`include "assert_macros.svh"

module blgr_chk import blgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] lapse_rate,
	input logic saturated,
	input logic domain_error
);

	localparam int MAX_FLIGHT = PIPE_DEPTH + 2;

	logic [6:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 7'(in_acc) - 7'(out_acc);
		end
	end

	`BLGR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(lapse_rate) && $stable(saturated) && $stable(domain_error), "result changed while stalled")
	`BLGR_ASSERT(a_no_phantom, out_valid |-> cnt_q != 7'd0, "result item without an accepted input item")
	`BLGR_ASSERT(a_bounded, cnt_q <= 7'(MAX_FLIGHT), "more items in flight than the pipeline holds")
	`BLGR_ASSERT(a_domain, out_valid && domain_error |-> lapse_rate == 32'sd0 && !saturated, "domain error with nonzero rate or clip flag")
	`BLGR_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid during reset")

endmodule

bind bssn_lapse_gauge_rate blgr_chk u_chk (.*);

// ===== bench/bssn_lapse_gauge_rate_tb.sv =====
// Self-checking bench for the lapse gauge rate block: random and corner grid points
// under every gauge mode, results predicted in the bench and compared in order.
// Depends on blgr_pkg and the bssn_lapse_gauge_rate RTL.
`timescale 1ns / 1ps

module bssn_lapse_gauge_rate_tb;
	import blgr_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 60;

	typedef struct {
		logic signed [31:0] rate;
		logic clip;
		logic derr;
	} rate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] lapse = '0, curv_trace = '0, conf_factor = '0;
	logic signed [31:0] shift_x = '0, shift_y = '0, shift_z = '0;
	logic signed [31:0] lapse_dx = '0, lapse_dy = '0, lapse_dz = '0;
	logic signed [31:0] background_curv = '0, curv_difference = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] lapse_rate;
	logic saturated;
	logic domain_error;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	int n_points = 0;

	always #5 clk = ~clk;

	bssn_lapse_gauge_rate i_dut (.*);

	// predictor state: register copies
	logic [2:0] mode_q = MODE_STATIC;
	logic signed [63:0] k0_q = 0, coef_q = 64'sd1 <<< FRAC_BITS;
	logic signed [63:0] mu_q = 0, pw_q = 0;
	bit clipped;

	function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clipped = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] fmul(input logic signed [63:0] x, y);
		return clip32((x * y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	// natural log by binary-log squaring iteration
	function automatic logic signed [63:0] fx_log(input logic signed [63:0] a);
		int k;
		logic [63:0] m;
		logic [63:0] frac;
		logic signed [127:0] w;
		k = 0;
		frac = 0;
		while (k < 31 && (a >> (k + 1)) != 0) k++;
		m = a << (31 - k);
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		w = (128'(signed'(k - FRAC_BITS)) <<< 32) + 128'(frac);
		w = w * 128'sd23258160 + (128'sd1 <<< (LN_SHIFT - 1));
		return clip32(64'(w >>> LN_SHIFT));
	endfunction

	function automatic rate_t predict_rate(input logic signed [31:0] f[11]);
		logic signed [63:0] a, kc, r, adv, t, a2, n;
		rate_t e;
		a = f[0];
		kc = f[1];
		r = 0;
		e.derr = 0;
		clipped = 0;
		adv = fmul(f[3], f[6]) + fmul(f[4], f[7]) + fmul(f[5], f[8]);
		case (mode_q)
			MODE_HARMONIC: begin
				a2 = fmul(a, a);
				r = clip32(-fmul(a2, clip32(kc - k0_q)));
			end
			MODE_ANHARM: begin
				a2 = fmul(a, a);
				r = fmul(a2, clip32(kc + (64'sd3 <<< FRAC_BITS)));
			end
			MODE_ONE_LOG: begin
				t = fmul(fmul(a, kc), coef_q);
				r = clip32(-2 * t + adv);
			end
			MODE_DAMPED: begin
				if (a <= 0) begin
					e.derr = 1;
					clipped = 0;
				end else begin
					t = clip32(12 * fmul(f[2], pw_q));
					t = clip32(t - fx_log(a));
					t = clip32(fmul(mu_q, t) - kc);
					a2 = fmul(a, a);
					r = clip32(fmul(a2, t) + adv);
				end
			end
			MODE_SYNC: begin
				n = -fmul(a, f[9]);
				r = (n >= 0) ? (n + 1) / 3 : -((-n + 1) / 3);
				r = clip32(r);
			end
			MODE_GWAVE: begin
				a2 = fmul(a, a);
				r = clip32(-fmul(a2, f[10]));
			end
			default: r = 0;
		endcase
		// advection products only clip in the modes that use them
		if (!(mode_q inside {MODE_ONE_LOG, MODE_DAMPED}) || e.derr) begin
			clipped = 0;
			case (mode_q)
				MODE_HARMONIC: begin
					a2 = fmul(a, a);
					void'(clip32(-fmul(a2, clip32(kc - k0_q))));
				end
				MODE_ANHARM: begin
					a2 = fmul(a, a);
					void'(fmul(a2, clip32(kc + (64'sd3 <<< FRAC_BITS))));
				end
				MODE_SYNC: begin
					n = -fmul(a, f[9]);
					void'(clip32((n >= 0) ? (n + 1) / 3 : -((-n + 1) / 3)));
				end
				MODE_GWAVE: begin
					a2 = fmul(a, a);
					void'(clip32(-fmul(a2, f[10])));
				end
				default: ;
			endcase
		end
		e.rate = r[31:0];
		e.clip = clipped;
		return e;
	endfunction

	class rate_board;
		rate_t pending[$];
		int errors = 0;
		int checked = 0;

		function void note_point(input rate_t e);
			pending.push_back(e);
		endfunction

		function void check_rate(input logic signed [31:0] r, input logic c, d);
			rate_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: actual %h/%b/%b", $time, r, c, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.rate !== r) begin
				$display("%0t lapse_rate: expected %h actual %h", $time, e.rate, r);
				errors++;
			end
			if (e.clip !== c) begin
				$display("%0t saturated: expected %b actual %b", $time, e.clip, c);
				errors++;
			end
			if (e.derr !== d) begin
				$display("%0t domain_error: expected %b actual %b", $time, e.derr, d);
				errors++;
			end
		endfunction
	endclass

	rate_board board = new();

	// result side: random backpressure, check on every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) board.check_rate(lapse_rate, saturated, domain_error);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired with %0d results pending", board.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// valid stays high after the handshake; send_point drops it
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE: mode_q = val[2:0];
			REG_K_OFFSET: k0_q = signed'(val);
			REG_LOG_COEF: coef_q = signed'(val);
			REG_DAMPING: mu_q = signed'(val);
			REG_POWER: pw_q = signed'(val);
			default: ;
		endcase
	endtask

	// valid stays high after the handshake; idling or drain drops it
	task automatic send_point(input logic signed [31:0] f[11]);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{lapse, curv_trace, conf_factor} <= {f[0], f[1], f[2]};
		{shift_x, shift_y, shift_z} <= {f[3], f[4], f[5]};
		{lapse_dx, lapse_dy, lapse_dz} <= {f[6], f[7], f[8]};
		{background_curv, curv_difference} <= {f[9], f[10]};
		do @(posedge clk); while (!in_ready);
		board.note_point(predict_rate(f));
		n_points++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// mix of corners, small magnitudes and full-range values
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return signed'($urandom_range(32'h0400_0000));
			3: return -signed'($urandom_range(32'h0400_0000));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_regs(input logic [2:0] mode);
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_K_OFFSET, pick_value());
		write_reg(REG_LOG_COEF, pick_value());
		write_reg(REG_DAMPING, pick_value());
		write_reg(REG_POWER, pick_value());
	endtask

	initial begin
		logic signed [31:0] f[11];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every mode, extremes, non-positive lapse, undefined mode
		for (int m = 0; m < 8; m++) begin
			write_reg(REG_MODE, 32'(m));
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 11; i++)
					f[i] = (j == 0) ? 32'sh7FFFFFFF : (j == 1) ? 32'sh80000000 : ONE_FX;
				if (j == 2) f[1] = '0;
				send_point(f);
			end
			drain();
		end

		// random phases with the three idling profiles
		for (int ph = 0; ph < 24; ph++) begin
			send_idle_pct = (ph < 8) ? 28 : (ph < 16) ? 54 : 0;
			recv_idle_pct = (ph < 8) ? 54 : (ph < 16) ? 28 : 0;
			random_regs(3'(ph % 8));
			if (ph == 5) begin
				write_reg(REG_K_OFFSET, 32'h7FFFFFFF);
				write_reg(REG_LOG_COEF, 32'h80000000);
				write_reg(REG_DAMPING, 32'h80000000);
				write_reg(REG_POWER, 32'h7FFFFFFF);
			end
			repeat (78) begin
				for (int i = 0; i < 11; i++) f[i] = pick_value();
				if (mode_q == MODE_DAMPED && $urandom_range(3) != 0 && f[0] <= 0)
					f[0] = (f[0] == 32'sh80000000) ? 32'sd1 : -f[0] + 1;
				send_point(f);
			end
			drain();
		end

		$display("%0d grid points sent over all gauge modes, %0d results checked",
			n_points, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/blgr_pkg.sv
hdl/blgr_ln.sv
hdl/bssn_lapse_gauge_rate.sv
hdl/blgr_chk.sv
bench/bssn_lapse_gauge_rate_tb.sv
